FILE: design/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types and constants shared by the header line parser modules.
// ----------------------------------------------------------------------------
package hhlp_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;

	localparam logic [15:0] KEY_MAX          = 16'hFFFF;
	localparam logic [9:0]  RESET_MAX_OFFSET = 10'd255;

	typedef enum logic [8:0] {
		ST_START  = 9'b000000001,
		ST_KEY    = 9'b000000010,
		ST_COLON  = 9'b000000100,
		ST_SPACE  = 9'b000001000,
		ST_VALUE  = 9'b000010000,
		ST_CR     = 9'b000100000,
		ST_LF     = 9'b001000000,
		ST_END_CR = 9'b010000000,
		ST_BODY   = 9'b100000000
	} parse_state_t;

	typedef enum logic [1:0] {
		CLS_SEP   = 2'd0,
		CLS_KEY   = 2'd1,
		CLS_VALUE = 2'd2,
		CLS_BODY  = 2'd3
	} byte_class_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_KEY_CRLF   = 3'd1,
		ERR_NO_SPACE   = 3'd2,
		ERR_VALUE_LONG = 3'd3,
		ERR_LINE_CR    = 3'd4,
		ERR_END_CR     = 3'd5
	} error_code_t;

	typedef struct packed {
		parse_state_t state;
		logic [15:0]  key_count;
		logic [10:0]  value_count;
		error_code_t  sticky_error;
	} parse_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		byte_class_t byte_class;
		logic        pair_done;
		logic [15:0] key_length;
		logic [10:0] value_length;
		logic        headers_done;
		error_code_t error_code;
	} result_t;

endpackage

FILE: design/hhlp_in_if.sv
// ----------------------------------------------------------------------------
// hhlp_in_if
// Input byte channel of the header line parser.
// ----------------------------------------------------------------------------
interface hhlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_request;

	modport source (output valid, output data_byte, output first_of_request, input ready);
	modport sink (input valid, input data_byte, input first_of_request, output ready);
endinterface

FILE: design/hhlp_out_if.sv
// ----------------------------------------------------------------------------
// hhlp_out_if
// Tagged byte result channel of the header line parser.
// ----------------------------------------------------------------------------
interface hhlp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  byte_class;
	logic        pair_done;
	logic [15:0] key_length;
	logic [10:0] value_length;
	logic        headers_done;
	logic [2:0]  error_code;

	modport source (output valid, output out_byte, output byte_class, output pair_done,
		output key_length, output value_length, output headers_done, output error_code,
		input ready);
	modport sink (input valid, input out_byte, input byte_class, input pair_done,
		input key_length, input value_length, input headers_done, input error_code,
		output ready);
endinterface

FILE: design/hhlp_step.sv
// ----------------------------------------------------------------------------
// hhlp_step
// Next-state and result logic for one header byte.
// ----------------------------------------------------------------------------
module hhlp_step (
	input  hhlp_pkg::parse_t  cur,
	input  logic [7:0]        data_byte,
	input  logic              first_of_request,
	input  logic [9:0]        max_value_offset,
	output hhlp_pkg::parse_t  nxt,
	output hhlp_pkg::result_t res
);

	hhlp_pkg::parse_t      base;
	hhlp_pkg::error_code_t err;
	hhlp_pkg::byte_class_t cls;
	logic                  pair;
	logic                  hdone;

	always_comb begin
		base = cur;
		if (first_of_request) begin
			base.state        = hhlp_pkg::ST_START;
			base.key_count    = 16'd0;
			base.value_count  = 11'd0;
			base.sticky_error = hhlp_pkg::ERR_NONE;
		end
		nxt   = base;
		err   = hhlp_pkg::ERR_NONE;
		cls   = hhlp_pkg::CLS_SEP;
		pair  = 1'b0;
		hdone = 1'b0;
		if (base.sticky_error == hhlp_pkg::ERR_NONE) begin
			case (base.state)
				hhlp_pkg::ST_KEY: begin
					if (data_byte == hhlp_pkg::CH_COLON) begin
						nxt.state = hhlp_pkg::ST_COLON;
					end else if (data_byte == hhlp_pkg::CH_CR || data_byte == hhlp_pkg::CH_LF) begin
						err = hhlp_pkg::ERR_KEY_CRLF;
					end else begin
						if (base.key_count != hhlp_pkg::KEY_MAX)
							nxt.key_count = base.key_count + 16'd1;
						cls = hhlp_pkg::CLS_KEY;
					end
				end
				hhlp_pkg::ST_COLON: begin
					if (data_byte == hhlp_pkg::CH_SP)
						nxt.state = hhlp_pkg::ST_SPACE;
					else
						err = hhlp_pkg::ERR_NO_SPACE;
				end
				hhlp_pkg::ST_SPACE: begin
					nxt.state       = hhlp_pkg::ST_VALUE;
					nxt.value_count = 11'd1;
					cls             = hhlp_pkg::CLS_VALUE;
				end
				hhlp_pkg::ST_VALUE: begin
					if (data_byte == hhlp_pkg::CH_CR) begin
						nxt.state = hhlp_pkg::ST_CR;
					end else if (base.value_count > {1'b0, max_value_offset}) begin
						err = hhlp_pkg::ERR_VALUE_LONG;
					end else begin
						nxt.value_count = base.value_count + 11'd1;
						cls             = hhlp_pkg::CLS_VALUE;
					end
				end
				hhlp_pkg::ST_CR: begin
					if (data_byte == hhlp_pkg::CH_LF) begin
						nxt.state = hhlp_pkg::ST_LF;
						pair      = 1'b1;
					end else begin
						err = hhlp_pkg::ERR_LINE_CR;
					end
				end
				hhlp_pkg::ST_LF: begin
					if (data_byte == hhlp_pkg::CH_CR) begin
						nxt.state = hhlp_pkg::ST_END_CR;
					end else begin
						nxt.state     = hhlp_pkg::ST_KEY;
						nxt.key_count = 16'd1;
						cls           = hhlp_pkg::CLS_KEY;
					end
				end
				hhlp_pkg::ST_END_CR: begin
					if (data_byte == hhlp_pkg::CH_LF) begin
						nxt.state = hhlp_pkg::ST_BODY;
						hdone     = 1'b1;
					end else begin
						err = hhlp_pkg::ERR_END_CR;
					end
				end
				hhlp_pkg::ST_BODY: begin
					cls = hhlp_pkg::CLS_BODY;
				end
				default: begin
					if (data_byte != hhlp_pkg::CH_CR && data_byte != hhlp_pkg::CH_LF) begin
						nxt.state     = hhlp_pkg::ST_KEY;
						nxt.key_count = 16'd1;
						cls           = hhlp_pkg::CLS_KEY;
					end else begin
						nxt.state = hhlp_pkg::ST_START;
					end
				end
			endcase
			if (err != hhlp_pkg::ERR_NONE) begin
				nxt              = base;
				nxt.sticky_error = err;
				cls              = hhlp_pkg::CLS_SEP;
			end
		end
		res.out_byte     = data_byte;
		res.byte_class   = cls;
		res.pair_done    = pair;
		res.key_length   = pair ? base.key_count : 16'd0;
		res.value_length = pair ? base.value_count : 11'd0;
		res.headers_done = hdone;
		res.error_code   = nxt.sticky_error;
	end

endmodule

FILE: design/http_header_line_parser.sv
// ----------------------------------------------------------------------------
// http_header_line_parser
// Tags header bytes as key, value, separator or body and reports pairs.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle and its result passes two registers: an
// input register feeds the combinational parse step, whose result lands in an
// output register. The state loop closes in that step, so throughput is one
// byte per clock while the output side keeps taking results. The user must
// write max_value_offset through the cfg channel only while idle; not enforced.
module http_header_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	hhlp_in_if.sink    in_ch,
	hhlp_out_if.source out_ch,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);

	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              first_s1;
	logic              v_s2;
	hhlp_pkg::result_t res_s2;
	hhlp_pkg::parse_t  parse_q;
	logic [9:0]        max_q;
	hhlp_pkg::parse_t  parse_nxt;
	hhlp_pkg::result_t res_nxt;
	logic              adv2;

	assign adv2        = !v_s2 || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv2;
	assign cfg_ready   = 1'b1;

	hhlp_step u_step (
		.cur              (parse_q),
		.data_byte        (byte_s1),
		.first_of_request (first_s1),
		.max_value_offset (max_q),
		.nxt              (parse_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1                 <= 1'b0;
			v_s2                 <= 1'b0;
			max_q                <= hhlp_pkg::RESET_MAX_OFFSET;
			parse_q.state        <= hhlp_pkg::ST_START;
			parse_q.key_count    <= 16'd0;
			parse_q.value_count  <= 11'd0;
			parse_q.sticky_error <= hhlp_pkg::ERR_NONE;
		end else begin
			if (cfg_valid)
				max_q <= cfg_data;
			if (in_ch.valid && in_ch.ready)
				v_s1 <= 1'b1;
			else if (adv2)
				v_s1 <= 1'b0;
			if (adv2)
				v_s2 <= v_s1;
			if (v_s1 && adv2)
				parse_q <= parse_nxt;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.data_byte;
			first_s1 <= in_ch.first_of_request;
		end
		if (v_s1 && adv2)
			res_s2 <= res_nxt;
	end

	assign out_ch.valid        = v_s2;
	assign out_ch.out_byte     = res_s2.out_byte;
	assign out_ch.byte_class   = res_s2.byte_class;
	assign out_ch.pair_done    = res_s2.pair_done;
	assign out_ch.key_length   = res_s2.key_length;
	assign out_ch.value_length = res_s2.value_length;
	assign out_ch.headers_done = res_s2.headers_done;
	assign out_ch.error_code   = res_s2.error_code;

endmodule

FILE: bench/http_header_line_parser_check.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_check
// Watches the byte, result and cfg channels of the header line parser. Each
// accepted byte is run through a local copy of the parse state machine, and
// each result transfer is compared field by field with the oldest tag that
// is still outstanding.
// ----------------------------------------------------------------------------
module http_header_line_parser_check
	import hhlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hhlp_in_if         in_mon,
	hhlp_out_if        out_mon,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [9:0] cfg_data,
	output int         mismatch_count,
	output int         tags_in_flight
);

	parse_state_t pstate     = ST_START;
	logic [15:0]  key_cnt    = '0;
	logic [10:0]  val_cnt    = '0;
	error_code_t  hold_err   = ERR_NONE;
	logic [9:0]   max_offset = RESET_MAX_OFFSET;
	result_t      tag_fifo[$];

	function automatic void clear_parse();
		pstate   = ST_START;
		key_cnt  = '0;
		val_cnt  = '0;
		hold_err = ERR_NONE;
	endfunction

	function automatic result_t tag_byte(input logic [7:0] b, input logic first);
		result_t     r;
		error_code_t err;
		r          = '0;
		r.out_byte = b;
		r.byte_class = CLS_SEP;
		err        = ERR_NONE;
		if (first)
			clear_parse();
		if (hold_err == ERR_NONE) begin
			case (pstate)
				ST_KEY: begin
					if (b == CH_COLON)
						pstate = ST_COLON;
					else if (b == CH_CR || b == CH_LF)
						err = ERR_KEY_CRLF;
					else begin
						if (key_cnt != KEY_MAX)
							key_cnt = key_cnt + 16'd1;
						r.byte_class = CLS_KEY;
					end
				end
				ST_COLON: begin
					if (b == CH_SP)
						pstate = ST_SPACE;
					else
						err = ERR_NO_SPACE;
				end
				ST_SPACE: begin
					pstate = ST_VALUE;
					val_cnt = 11'd1;
					r.byte_class = CLS_VALUE;
				end
				ST_VALUE: begin
					if (b == CH_CR)
						pstate = ST_CR;
					else if (val_cnt > {1'b0, max_offset})
						err = ERR_VALUE_LONG;
					else begin
						val_cnt = val_cnt + 11'd1;
						r.byte_class = CLS_VALUE;
					end
				end
				ST_CR: begin
					if (b == CH_LF) begin
						pstate = ST_LF;
						r.pair_done = 1'b1;
						r.key_length = key_cnt;
						r.value_length = val_cnt;
					end else
						err = ERR_LINE_CR;
				end
				ST_LF: begin
					if (b == CH_CR)
						pstate = ST_END_CR;
					else begin
						pstate = ST_KEY;
						key_cnt = 16'd1;
						r.byte_class = CLS_KEY;
					end
				end
				ST_END_CR: begin
					if (b == CH_LF) begin
						pstate = ST_BODY;
						r.headers_done = 1'b1;
					end else
						err = ERR_END_CR;
				end
				ST_BODY: r.byte_class = CLS_BODY;
				default: begin
					if (b != CH_CR && b != CH_LF) begin
						pstate = ST_KEY;
						key_cnt = 16'd1;
						r.byte_class = CLS_KEY;
					end else
						pstate = ST_START;
				end
			endcase
			if (err != ERR_NONE) begin
				hold_err = err;
				r.byte_class = CLS_SEP;
			end
		end
		r.error_code = hold_err;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			clear_parse();
			max_offset = RESET_MAX_OFFSET;
			tag_fifo.delete();
			tags_in_flight = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got.out_byte     = out_mon.out_byte;
				got.byte_class   = byte_class_t'(out_mon.byte_class);
				got.pair_done    = out_mon.pair_done;
				got.key_length   = out_mon.key_length;
				got.value_length = out_mon.value_length;
				got.headers_done = out_mon.headers_done;
				got.error_code   = error_code_t'(out_mon.error_code);
				if (tag_fifo.size() == 0) begin
					$error("result transfer with no byte outstanding");
					mismatch_count++;
				end else begin
					want = tag_fifo.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
						mismatch_count++;
					end
					if (got.byte_class !== want.byte_class) begin
						$error("byte_class expected %0d actual %0d", want.byte_class,
							got.byte_class);
						mismatch_count++;
					end
					if (got.pair_done !== want.pair_done) begin
						$error("pair_done expected %0d actual %0d", want.pair_done,
							got.pair_done);
						mismatch_count++;
					end
					if (got.key_length !== want.key_length) begin
						$error("key_length expected %0d actual %0d", want.key_length,
							got.key_length);
						mismatch_count++;
					end
					if (got.value_length !== want.value_length) begin
						$error("value_length expected %0d actual %0d", want.value_length,
							got.value_length);
						mismatch_count++;
					end
					if (got.headers_done !== want.headers_done) begin
						$error("headers_done expected %0d actual %0d", want.headers_done,
							got.headers_done);
						mismatch_count++;
					end
					if (got.error_code !== want.error_code) begin
						$error("error_code expected %0d actual %0d", want.error_code,
							got.error_code);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				max_offset = cfg_data;
			if (in_mon.valid && in_mon.ready)
				tag_fifo.push_back(tag_byte(in_mon.data_byte, in_mon.first_of_request));
			tags_in_flight = tag_fifo.size();
		end
	end

endmodule

FILE: bench/http_header_line_parser_tb.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_tb
// Drives header streams into the parser: well-formed requests with random
// keys, values and bodies, requests broken by each kind of framing error,
// and noise. max_value_offset is swept over several settings including its
// extremes. The sender works in bursts, the receiver stalls on its own
// pattern, and the checker beside the block counts mismatches.
// ----------------------------------------------------------------------------
module http_header_line_parser_tb;
	import hhlp_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [9:0] cfg_data;
	int         mismatch_count;
	int         tags_in_flight;

	hhlp_in_if  in_if();
	hhlp_out_if out_if();

	bit         start_flag = 1'b0;
	bit         broken     = 1'b0;
	int         burst_left = 0;
	int         sent_count = 0;
	logic [9:0] cur_max    = RESET_MAX_OFFSET;
	int         rx_mode    = 0;
	int         rx_left    = 0;

	always #4 clk = ~clk;

	http_header_line_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	http_header_line_parser_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_mon         (in_if),
		.out_mon        (out_if),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.tags_in_flight (tags_in_flight)
	);

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n)
			out_if.ready <= 1'b0;
		else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = (rx_mode == 3) ? $urandom_range(2, 25) : $urandom_range(10, 120);
			end else
				rx_left--;
			case (rx_mode)
				0:       out_if.ready <= 1'b1;
				1:       out_if.ready <= ($urandom_range(0, 3) != 0);
				2:       out_if.ready <= ($urandom_range(0, 3) == 0);
				default: out_if.ready <= 1'b0;
			endcase
		end
	end

	function automatic logic [7:0] key_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COLON || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] any_but(input logic [7:0] x);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == x);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		in_if.valid            <= 1'b1;
		in_if.data_byte        <= b;
		in_if.first_of_request <= start_flag;
		start_flag = 1'b0;
		do
			@(posedge clk);
		while (!in_if.ready);
		sent_count++;
		if (burst_left == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end else
			burst_left--;
	endtask

	task automatic set_max_offset(input logic [9:0] v);
		in_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tags_in_flight != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_max = v;
	endtask

	task automatic send_line(input bit first_line, input int fault);
		int klen;
		int vlen;
		int bad_at;
		int i;
		klen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
		if (first_line)
			send_byte(key_byte());
		else
			case ($urandom_range(0, 7))
				0:       send_byte(CH_LF);
				1:       send_byte(CH_COLON);
				default: send_byte(key_byte());
			endcase
		bad_at = $urandom_range(1, klen);
		for (i = 1; i <= klen; i++) begin
			if (fault == ERR_KEY_CRLF && i == bad_at) begin
				send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				broken = 1'b1;
				return;
			end
			if (i < klen)
				send_byte(key_byte());
		end
		send_byte(CH_COLON);
		if (fault == ERR_NO_SPACE) begin
			send_byte(any_but(CH_SP));
			broken = 1'b1;
			return;
		end
		send_byte(CH_SP);
		vlen = $urandom_range(1, 8);
		if ($urandom_range(0, 5) == 0 && cur_max <= 60)
			vlen = cur_max + 1;
		if (fault == ERR_VALUE_LONG && cur_max <= 60)
			vlen = cur_max + 2;
		else if (vlen > cur_max + 1)
			vlen = cur_max + 1;
		send_byte(($urandom_range(0, 7) == 0) ? CH_CR : 8'($urandom_range(0, 255)));
		for (i = 1; i < vlen; i++)
			send_byte(any_but(CH_CR));
		if (fault == ERR_VALUE_LONG && cur_max <= 60) begin
			broken = 1'b1;
			return;
		end
		send_byte(CH_CR);
		if (fault == ERR_LINE_CR) begin
			send_byte(any_but(CH_LF));
			broken = 1'b1;
			return;
		end
		send_byte(CH_LF);
	endtask

	task automatic send_noise();
		start_flag = $urandom_range(0, 1);
		repeat ($urandom_range(3, 20)) begin
			if ($urandom_range(0, 15) == 0)
				start_flag = 1'b1;
			case ($urandom_range(0, 5))
				0:       send_byte(CH_COLON);
				1:       send_byte(CH_SP);
				2:       send_byte(CH_CR);
				3:       send_byte(CH_LF);
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic send_request();
		int nlines;
		int fault;
		int fault_line;
		int i;
		if ($urandom_range(0, 9) == 0) begin
			send_noise();
			return;
		end
		start_flag = 1'b1;
		repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
		nlines = $urandom_range(1, 5);
		fault = ($urandom_range(0, 3) == 0) ? $urandom_range(ERR_KEY_CRLF, ERR_END_CR) : 0;
		fault_line = $urandom_range(0, nlines - 1);
		broken = 1'b0;
		for (i = 0; i < nlines && !broken; i++)
			send_line(i == 0, (i == fault_line) ? fault : 0);
		if (!broken) begin
			send_byte(CH_CR);
			if (fault == ERR_END_CR) begin
				send_byte(any_but(CH_LF));
				broken = 1'b1;
			end else
				send_byte(CH_LF);
		end
		repeat ($urandom_range(0, broken ? 3 : 6)) send_byte(8'($urandom_range(0, 255)));
	endtask

	// longest legal value at the widest limit
	task automatic send_widest_value();
		start_flag = 1'b1;
		repeat (3) send_byte(key_byte());
		send_byte(CH_COLON);
		send_byte(CH_SP);
		send_byte(8'($urandom_range(0, 255)));
		repeat (1023) send_byte(any_but(CH_CR));
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	initial begin
		logic [7:0] err_seq[]  = '{8'h61, CH_CR, 8'h78};
		logic [7:0] good_seq[] = '{CH_CR, CH_LF, CH_COLON, 8'hFF, 8'h00, CH_COLON, CH_SP,
			CH_CR, 8'h7F, CH_CR, CH_LF, CH_LF, CH_COLON, CH_SP, 8'h80, CH_CR, CH_LF,
			CH_CR, CH_LF, 8'h00, 8'hFF};
		logic [9:0] plan[];
		int phase_end;
		int p;

		arst_n                 = 1'b0;
		in_if.valid            = 1'b0;
		in_if.data_byte        = '0;
		in_if.first_of_request = 1'b0;
		cfg_valid              = 1'b0;
		cfg_data               = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		start_flag = 1'b1;
		foreach (err_seq[i])
			send_byte(err_seq[i]);
		start_flag = 1'b1;
		foreach (good_seq[i])
			send_byte(good_seq[i]);

		plan = '{10'd1023, 10'd0, 10'd1, 10'd3, 10'($urandom_range(2, 60)),
			10'($urandom_range(61, 1022)), 10'd1023, 10'($urandom_range(4, 20))};
		for (p = 0; p < plan.size(); p++) begin
			set_max_offset(plan[p]);
			if (p == 0)
				send_widest_value();
			phase_end = sent_count + 80;
			while (sent_count < phase_end)
				send_request();
		end

		in_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tags_in_flight != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && tags_in_flight == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/hhlp_pkg.sv
design/hhlp_in_if.sv
design/hhlp_out_if.sv
design/hhlp_step.sv
design/http_header_line_parser.sv
bench/http_header_line_parser_check.sv
bench/http_header_line_parser_tb.sv
